// File: rtl/dwbp_pkg.sv
package dwbp_pkg;

    // Operation codes of an input transaction
    localparam logic [2:0] OP_PUSH_LEFT  = 3'd0;
    localparam logic [2:0] OP_PUSH_RIGHT = 3'd1;
    localparam logic [2:0] OP_POP_LEFT   = 3'd2;
    localparam logic [2:0] OP_POP_RIGHT  = 3'd3;
    localparam logic [2:0] OP_DUMP       = 3'd4;

    // Command classes handed from the front end to the back end
    localparam logic [2:0] KIND_NOP       = 3'd0;
    localparam logic [2:0] KIND_PUSH_LEFT = 3'd1;
    localparam logic [2:0] KIND_PUSH_RIGHT= 3'd2;
    localparam logic [2:0] KIND_POP_LEFT  = 3'd3;
    localparam logic [2:0] KIND_POP_RIGHT = 3'd4;
    localparam logic [2:0] KIND_DUMP      = 3'd5;

    // Result status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_FULL    = 2'd1;
    localparam logic [1:0] STATUS_CLEARED = 2'd2;

    // Field widths
    localparam int OP_W     = 3;
    localparam int VALUE_W  = 32;
    localparam int AMOUNT_W = 16;
    localparam int OCC_W    = 7;
    localparam int STATUS_W = 2;

    typedef struct packed {
        logic [2:0]                 kind;
        logic signed [VALUE_W-1:0]  value;
        logic [AMOUNT_W-1:0]        amount;
    } cmd_t;

endpackage

// File: rtl/dwbp_front.sv
module dwbp_front
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [dwbp_pkg::OP_W-1:0]           operation,
    input  logic signed [dwbp_pkg::VALUE_W-1:0] push_value,
    input  logic [dwbp_pkg::AMOUNT_W-1:0]       pop_amount,
    output logic                                cmd_valid,
    output dwbp_pkg::cmd_t                      cmd,
    input  logic                                cmd_take
);

    // Two-entry command queue
    dwbp_pkg::cmd_t entry_reg [2];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     fill_reg;
    logic [1:0]     fill_next;
    logic           accept;
    dwbp_pkg::cmd_t classified;

    assign busy   = (fill_reg == 2'd2);
    assign accept = start && !busy;

    // Classify the incoming operation
    always_comb
    begin
        classified.value  = push_value;
        classified.amount = pop_amount;
        case (operation)
            dwbp_pkg::OP_PUSH_LEFT:  classified.kind = dwbp_pkg::KIND_PUSH_LEFT;
            dwbp_pkg::OP_PUSH_RIGHT: classified.kind = dwbp_pkg::KIND_PUSH_RIGHT;
            dwbp_pkg::OP_POP_LEFT:   classified.kind = dwbp_pkg::KIND_POP_LEFT;
            dwbp_pkg::OP_POP_RIGHT:  classified.kind = dwbp_pkg::KIND_POP_RIGHT;
            dwbp_pkg::OP_DUMP:       classified.kind = dwbp_pkg::KIND_DUMP;
            default:                 classified.kind = dwbp_pkg::KIND_NOP;
        endcase
    end

    assign cmd_valid = (fill_reg != 2'd0);
    assign cmd       = entry_reg[rd_ptr_reg];

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (accept)
        begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (cmd_take)
        begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if (accept && !cmd_take)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (!accept && cmd_take)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Hold the accepted command
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            entry_reg[wr_ptr_reg] <= classified;
        end
    end

endmodule

// File: rtl/dwbp_back.sv
module dwbp_back
#(
    parameter int DEPTH = 64
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cmd_valid,
    input  dwbp_pkg::cmd_t                       cmd,
    output logic                                 cmd_take,
    output logic                                 result_valid,
    output logic signed [dwbp_pkg::VALUE_W-1:0]  element,
    output logic                                 element_valid,
    output logic                                 last,
    output logic [dwbp_pkg::OCC_W-1:0]           occupancy,
    output logic [dwbp_pkg::STATUS_W-1:0]        status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = PTR_W + 1;

    localparam logic ST_RUN  = 1'b0;
    localparam logic ST_DUMP = 1'b1;

    logic signed [dwbp_pkg::VALUE_W-1:0] mem [DEPTH];
    logic signed [dwbp_pkg::VALUE_W-1:0] mem_q_reg;

    logic                          state_reg;
    logic                          state_next;
    logic [PTR_W-1:0]              front_reg;
    logic [PTR_W-1:0]              front_next;
    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              count_next;
    logic [PTR_W-1:0]              rd_ptr_reg;
    logic [PTR_W-1:0]              rd_ptr_next;
    logic [CNT_W-1:0]              left_reg;
    logic [CNT_W-1:0]              left_next;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic                          elem_valid_reg;
    logic                          elem_valid_next;
    logic                          last_reg;
    logic                          last_next;
    logic [CNT_W-1:0]              occ_reg;
    logic [CNT_W-1:0]              occ_next;
    logic [dwbp_pkg::STATUS_W-1:0] status_reg;
    logic [dwbp_pkg::STATUS_W-1:0] status_next;

    logic                          wr_en;
    logic [PTR_W-1:0]              wr_addr;
    logic [SUM_W-1:0]              tail_sum;
    logic [SUM_W-1:0]              pop_sum;
    logic [PTR_W-1:0]              rd_ptr_inc;

    // Fold a sum below twice the depth back into the ring
    function automatic logic [PTR_W-1:0] ring_fold(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] r;
        begin
            r = (s >= SUM_W'(DEPTH)) ? (s - SUM_W'(DEPTH)) : s;
            ring_fold = r[PTR_W-1:0];
        end
    endfunction

    assign cmd_take = (state_reg == ST_RUN) && cmd_valid;
    assign tail_sum = SUM_W'(front_reg) + SUM_W'(count_reg);
    assign pop_sum  = SUM_W'(front_reg) + cmd.amount[SUM_W-1:0];
    assign rd_ptr_inc = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);

    // Execute one command or one dump step per cycle
    always_comb
    begin
        state_next      = state_reg;
        front_next      = front_reg;
        count_next      = count_reg;
        rd_ptr_next     = rd_ptr_reg;
        left_next       = left_reg;
        out_valid_next  = 1'b0;
        elem_valid_next = 1'b0;
        last_next       = 1'b1;
        occ_next        = count_reg;
        status_next     = dwbp_pkg::STATUS_OK;
        wr_en           = 1'b0;
        wr_addr         = ring_fold(tail_sum);

        if (state_reg == ST_DUMP)
        begin
            out_valid_next  = 1'b1;
            elem_valid_next = 1'b1;
            last_next       = (left_reg == CNT_W'(1));
            rd_ptr_next     = rd_ptr_inc;
            left_next       = left_reg - CNT_W'(1);
            if (left_reg == CNT_W'(1))
            begin
                state_next = ST_RUN;
            end
        end
        else if (cmd_take)
        begin
            out_valid_next = 1'b1;
            case (cmd.kind)
                dwbp_pkg::KIND_PUSH_LEFT,
                dwbp_pkg::KIND_PUSH_RIGHT:
                begin
                    if (count_reg == CNT_W'(DEPTH))
                    begin
                        status_next = dwbp_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                        occ_next   = count_reg + CNT_W'(1);
                        if (cmd.kind == dwbp_pkg::KIND_PUSH_LEFT)
                        begin
                            front_next = (front_reg == '0) ? PTR_W'(DEPTH - 1)
                                                           : front_reg - PTR_W'(1);
                            wr_addr    = front_next;
                        end
                    end
                end
                dwbp_pkg::KIND_POP_LEFT,
                dwbp_pkg::KIND_POP_RIGHT:
                begin
                    if (cmd.amount > dwbp_pkg::AMOUNT_W'(count_reg))
                    begin
                        count_next  = '0;
                        occ_next    = '0;
                        front_next  = '0;
                        status_next = dwbp_pkg::STATUS_CLEARED;
                    end
                    else
                    begin
                        count_next = count_reg - cmd.amount[CNT_W-1:0];
                        occ_next   = count_reg - cmd.amount[CNT_W-1:0];
                        if (cmd.kind == dwbp_pkg::KIND_POP_LEFT)
                        begin
                            front_next = ring_fold(pop_sum);
                        end
                    end
                end
                dwbp_pkg::KIND_DUMP:
                begin
                    if (count_reg != '0)
                    begin
                        // Defer the results to the dump walk
                        out_valid_next = 1'b0;
                        state_next     = ST_DUMP;
                        rd_ptr_next    = front_reg;
                        left_next      = count_reg;
                    end
                end
                default:
                begin
                    status_next = dwbp_pkg::STATUS_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_RUN;
            front_reg      <= '0;
            count_reg      <= '0;
            rd_ptr_reg     <= '0;
            left_reg       <= '0;
            out_valid_reg  <= 1'b0;
            elem_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            front_reg      <= front_next;
            count_reg      <= count_next;
            rd_ptr_reg     <= rd_ptr_next;
            left_reg       <= left_next;
            out_valid_reg  <= out_valid_next;
            elem_valid_reg <= elem_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        last_reg   <= last_next;
        occ_reg    <= occ_next;
        status_reg <= status_next;
    end

    // Ring store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= cmd.value;
        end
        mem_q_reg <= mem[rd_ptr_reg];
    end

    assign result_valid  = out_valid_reg;
    assign element_valid = elem_valid_reg;
    assign element       = elem_valid_reg ? mem_q_reg : '0;
    assign last          = last_reg;
    assign occupancy     = dwbp_pkg::OCC_W'(occ_reg);
    assign status        = status_reg;

endmodule

// File: rtl/deque_with_bulk_pop_top.sv
// Double-ended queue of up to DEPTH signed 32-bit values in a ring store.
// Raise start with an operation while busy is low; the operation enters a
// two-entry command queue and the execution side works it off. Push, pop and
// unknown operations give one result each, in the cycle after the command
// is taken from the head of the queue. A dump of N stored elements holds the
// execution side for a step that loads the read pointer and then one
// ring-store read per element, and gives N results, left to right, with last
// on the final one; its first result follows the first ring-store read. An
// empty dump behaves like an unknown operation and gives one result. Results
// appear on the result ports for exactly one cycle, marked by result_valid,
// and cannot be held off: capture them when they appear. Results come out in
// the order the transactions were accepted. busy is high only while the
// command queue is full, which can only happen during a dump walk and in the
// cycle right after it.
module deque_with_bulk_pop_top
#(
    parameter int DEPTH = 64
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [dwbp_pkg::OP_W-1:0]           operation,
    input  logic signed [dwbp_pkg::VALUE_W-1:0] push_value,
    input  logic [dwbp_pkg::AMOUNT_W-1:0]       pop_amount,
    output logic                                result_valid,
    output logic signed [dwbp_pkg::VALUE_W-1:0] element,
    output logic                                element_valid,
    output logic                                last,
    output logic [dwbp_pkg::OCC_W-1:0]          occupancy,
    output logic [dwbp_pkg::STATUS_W-1:0]       status
);

    logic           cmd_valid;
    dwbp_pkg::cmd_t cmd;
    logic           cmd_take;

    dwbp_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .operation  (operation),
        .push_value (push_value),
        .pop_amount (pop_amount),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_take   (cmd_take)
    );

    dwbp_back #(.DEPTH(DEPTH)) u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_take      (cmd_take),
        .result_valid  (result_valid),
        .element       (element),
        .element_valid (element_valid),
        .last          (last),
        .occupancy     (occupancy),
        .status        (status)
    );

endmodule
